FILE: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also watches the reset cycles
`define ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/mtp_pkg.sv
// types, character codes and the saturating digit step of the term parser
`timescale 1ns / 1ps

package mtp_pkg;

  localparam logic [7:0] CHAR_X      = 8'h78;
  localparam logic [7:0] CHAR_CARET  = 8'h5E;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [31:0] COEF_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] POWER_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       end_of_term;
  } item_t;

  typedef struct packed {
    logic [31:0] coef_value;
    logic [31:0] power_value;
    logic        is_zero_term;
  } res_t;

  // acc * 10 + d, clamped to lim
  function automatic logic [31:0] sat_digit(input logic [31:0] acc, input logic [3:0] d,
                                            input logic [31:0] lim);
    logic [35:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, d};
    return (v > {4'd0, lim}) ? lim : v[31:0];
  endfunction

endpackage

FILE: sv/mtp_core.sv
// parser state registers and the per-character next-state and result logic
`timescale 1ns / 1ps

module mtp_core import mtp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,      // item in the input register is consumed this cycle
  input  item_t item,
  output res_t  res        // result for the item, valid when it ends the term
);

  logic        began_r, began_nxt;
  logic        rejected_r, rejected_nxt;
  logic        minus_r, minus_nxt;
  logic        var_r, var_nxt;
  logic        caret_r, caret_nxt;
  logic        halted_r, halted_nxt;
  logic [31:0] coef_r, coef_nxt;
  logic        coef_dig_r, coef_dig_nxt;
  logic [31:0] power_r, power_nxt;
  logic        power_dig_r, power_dig_nxt;

  logic        is_space;
  logic        is_digit;
  logic        cont;
  logic        has_value;
  logic [31:0] coef_out;
  logic [31:0] power_out;

  assign is_space = (item.char_code == CHAR_SPACE) ||
                    (item.char_code inside {[CHAR_TAB:CHAR_CR]});
  assign is_digit = item.char_code inside {[CHAR_ZERO:CHAR_NINE]};

  always_comb begin
    began_nxt     = began_r;
    rejected_nxt  = rejected_r;
    minus_nxt     = minus_r;
    var_nxt       = var_r;
    caret_nxt     = caret_r;
    halted_nxt    = halted_r;
    coef_nxt      = coef_r;
    coef_dig_nxt  = coef_dig_r;
    power_nxt     = power_r;
    power_dig_nxt = power_dig_r;
    cont          = 1'b1;
    if (item.char_present && !is_space && !rejected_r && !halted_r) begin
      if (!began_r) begin
        began_nxt = 1'b1;
        if (item.char_code == CHAR_MINUS) begin
          minus_nxt = 1'b1;
          cont      = 1'b0;
        end else if (!is_digit) begin
          rejected_nxt = 1'b1;
          cont         = 1'b0;
        end
      end
      if (cont) begin
        if (is_digit) begin
          if (caret_r) begin
            power_nxt     = sat_digit(power_r, item.char_code[3:0], POWER_MAX);
            power_dig_nxt = 1'b1;
          end else begin
            coef_nxt     = sat_digit(coef_r, item.char_code[3:0], COEF_MAX);
            coef_dig_nxt = 1'b1;
          end
        end else if (item.char_code == CHAR_X && !var_r) begin
          var_nxt = 1'b1;
        end else if (item.char_code == CHAR_CARET && var_r && !caret_r) begin
          caret_nxt = 1'b1;
        end else begin
          // stop: drop exponent digits, and the coefficient too before a caret
          if (!caret_r) begin
            coef_nxt     = 32'd0;
            coef_dig_nxt = 1'b0;
          end
          power_nxt     = 32'd0;
          power_dig_nxt = 1'b0;
          halted_nxt    = 1'b1;
        end
      end
    end
  end

  assign has_value = !rejected_nxt && (coef_dig_nxt || power_dig_nxt);
  assign coef_out  = !has_value ? 32'd0 : (minus_nxt ? (32'd0 - coef_nxt) : coef_nxt);
  assign power_out = !has_value ? 32'd0 :
                     (power_dig_nxt ? power_nxt : {31'd0, var_nxt});

  assign res.coef_value   = coef_out;
  assign res.power_value  = power_out;
  assign res.is_zero_term = (coef_out == 32'd0) && (power_out == 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.end_of_term)) begin
      began_r     <= 1'b0;
      rejected_r  <= 1'b0;
      minus_r     <= 1'b0;
      var_r       <= 1'b0;
      caret_r     <= 1'b0;
      halted_r    <= 1'b0;
      coef_r      <= 32'd0;
      coef_dig_r  <= 1'b0;
      power_r     <= 32'd0;
      power_dig_r <= 1'b0;
    end else if (step) begin
      began_r     <= began_nxt;
      rejected_r  <= rejected_nxt;
      minus_r     <= minus_nxt;
      var_r       <= var_nxt;
      caret_r     <= caret_nxt;
      halted_r    <= halted_nxt;
      coef_r      <= coef_nxt;
      coef_dig_r  <= coef_dig_nxt;
      power_r     <= power_nxt;
      power_dig_r <= power_dig_nxt;
    end
  end

endmodule

FILE: sv/mtp_out_reg.sv
// result register that drives the output stream
`timescale 1ns / 1ps

module mtp_out_reg import mtp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  res_t        res,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // coef_value [31:0], power_value [63:32]
  output logic        out_tuser    // is_zero_term
);

  logic valid_r, valid_nxt;
  res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.power_value, res_r.coef_value};
  assign out_tuser  = res_r.is_zero_term;

endmodule

FILE: sv/monomial_text_parser.sv
// top level of the monomial term parser: input register, parser core, result register
//
//   channel   dir  ports                          contents
//   in_       in   tvalid tready tdata tuser tlast  tdata char_code, tuser char_present,
//                                                   tlast end_of_term
//   out_      out  tvalid tready tdata tuser        tdata coef/power, tuser is_zero_term
//
// one character per cycle unless a held result stalls an end request; an end request
// passes the input register, then its result is loaded into the result register.
// the only loop is the multiply-by-ten accumulate in the core, one step per character;
// rst_n is synchronous; reset clears valid flags and the parser state. A held result
// stalls an end request in the input register and the input behind it; other characters keep flowing
`timescale 1ns / 1ps

module monomial_text_parser import mtp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // char_code
  input  logic        in_tuser,    // char_present
  input  logic        in_tlast,    // end_of_term
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // coef_value [31:0], power_value [63:32]
  output logic        out_tuser    // is_zero_term
);

  logic  in_valid_r, in_valid_nxt;
  item_t item_r;
  logic  take;
  logic  step;
  res_t  res;

  assign take = in_tvalid && in_tready;
  // an end item needs the result slot free or emptying
  assign step = in_valid_r && (!item_r.end_of_term || !out_tvalid || out_tready);
  assign in_tready = rst_n && (!in_valid_r || step);

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (take) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.char_code    <= in_tdata;
      item_r.char_present <= in_tuser;
      item_r.end_of_term  <= in_tlast;
    end
  end

  mtp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .res   (res)
  );

  mtp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && item_r.end_of_term),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: sv/mtp_checker.sv
// port-level checks on the parser result stream, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtp_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  logic        stalled;
  logic [64:0] out_word;

  assign stalled  = out_tvalid && !out_tready;
  assign out_word = {out_tuser, out_tdata};

  `ASSERT_NEXT(a_out_hold, stalled, out_tvalid && $stable(out_word), "stalled result changed")
  `ASSERT_IMPL(a_zero_flag, out_tvalid, out_tuser == (out_tdata == 64'd0), "zero flag mismatch")
  `ASSERT_IMPL(a_coef_range, out_tvalid, out_tdata[31:0] != 32'h8000_0000, "coef out of range")
  `ASSERT_ALWAYS_NEXT(a_reset_idle, !rst_n, !out_tvalid, "result valid right after reset")

endmodule

bind monomial_text_parser mtp_port_checks u_port_checks (.*);
